/* rtl/http_request_header_scanner_macros.svh */
// ----------------------------------------------------------------------------
// HTTP request header scanner assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_SCANNER_MACROS_SVH
`define HTTP_REQUEST_HEADER_SCANNER_MACROS_SVH

// same-cycle implication, disabled in reset
`define HRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hrs_pkg.sv */
// ----------------------------------------------------------------------------
// hrs_pkg
// Types and constants shared by the HTTP request header scanner.
// ----------------------------------------------------------------------------
package hrs_pkg;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_HTTP_PORT          = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PAYLOAD_LENGTH = 8'd1;

    localparam logic [15:0] HTTP_PORT_RESET   = 16'd80;
    localparam logic [15:0] MIN_LENGTH_RESET  = 16'd16;

    localparam logic [7:0]  CH_CR = 8'h0d;
    localparam logic [7:0]  CH_LF = 8'h0a;

    // byte k of the line sits at bits [8k+7:8k]
    localparam logic [39:0] PAT_POST = 40'h20_54_53_4f_50;
    localparam logic [31:0] PAT_GET  = 32'h20_54_45_47;
    localparam logic [39:0] PAT_HOST = 40'h3a_74_73_6f_48;

    typedef enum logic [1:0] {
        JEL_NONE  = 2'd0,
        JEL_LF    = 2'd1,
        JEL_LF_CR = 2'd2
    } jel_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] payload_length;
        logic        is_tcp;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } in_item_t;

    typedef struct packed {
        logic        request_found;
        logic        method_post;
        logic [15:0] url_offset;
        logic [15:0] url_length;
        logic        host_found;
        logic [15:0] host_offset;
        logic [15:0] host_length;
        logic        body_found;
        logic [15:0] body_offset;
        logic [15:0] body_length;
    } out_item_t;

    typedef struct packed {
        logic [15:0] http_port;
        logic [15:0] min_payload_length;
    } hrs_cfg_t;

    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] line_start;
        logic [39:0] prefix;
        logic [2:0]  pcnt;
        logic        prev_cr;
        jel_t        jel;
        logic        active;
        logic [15:0] len_held;
    } hrs_state_t;

endpackage

/* rtl/hrs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hrs_cfg_regs
// Configuration register file: HTTP port and minimum payload length.
// ----------------------------------------------------------------------------
module hrs_cfg_regs
    import hrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    output hrs_cfg_t               cfg
);

    hrs_cfg_t cfg_reg;
    hrs_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HTTP_PORT:          cfg_next.http_port          = cfg_data;
                REG_MIN_PAYLOAD_LENGTH: cfg_next.min_payload_length = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.http_port          <= HTTP_PORT_RESET;
            cfg_reg.min_payload_length <= MIN_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/hrs_in_reg.sv */
// ----------------------------------------------------------------------------
// hrs_in_reg
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
module hrs_in_reg
    import hrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    output logic     item_valid,
    output in_item_t item,
    input  logic     advance
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* rtl/hrs_parser.sv */
// ----------------------------------------------------------------------------
// hrs_parser
// Per-byte line scanner: tracks line starts, matches request and Host
// prefixes, detects the blank line and builds the held result.
// ----------------------------------------------------------------------------
module hrs_parser
    import hrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hrs_cfg_t  cfg,
    input  logic      item_valid,
    input  in_item_t  item,
    input  logic      result_free,
    output logic      advance,
    output logic      result_valid,
    output out_item_t result_item
);

    hrs_state_t state_reg;
    hrs_state_t state_next;
    out_item_t  hold_reg;
    out_item_t  hold_next;

    hrs_state_t st;
    out_item_t  hold;
    logic [7:0] b;
    logic [15:0] cr_pos;
    logic [16:0] host_end;
    logic       is_post;
    logic       is_get;
    logic       is_host;

    assign advance      = item_valid && (!item.last_byte || result_free);
    assign result_valid = advance && item.last_byte;

    always_comb
    begin
        st       = state_reg;
        hold     = hold_reg;
        b        = item.data_byte;
        cr_pos   = '0;
        host_end = '0;
        if (item.first_byte)
        begin
            st          = '0;
            hold        = '0;
            st.len_held = item.payload_length;
            st.active   = item.is_tcp
                          && (item.payload_length >= cfg.min_payload_length)
                          && (item.source_port == cfg.http_port
                              || item.dest_port == cfg.http_port);
        end
        is_post = (st.pcnt >= 3'd5) && (st.prefix == PAT_POST);
        is_get  = (st.pcnt >= 3'd4) && (st.prefix[31:0] == PAT_GET);
        is_host = (st.pcnt >= 3'd5) && (st.prefix == PAT_HOST);
        if (st.active && (st.pos < st.len_held))
        begin
            if (st.prev_cr && b == CH_LF)
            begin
                if (st.jel == JEL_LF_CR)
                begin
                    hold.body_found  = 1'b1;
                    hold.body_offset = st.pos + 16'd1;
                    hold.body_length = st.len_held - (st.pos + 16'd1);
                    st.active        = 1'b0;
                end
                else
                begin
                    cr_pos   = st.pos - 16'd1;
                    host_end = {1'b0, st.line_start} + 17'd6;
                    if (is_post)
                    begin
                        hold.request_found = 1'b1;
                        hold.method_post   = 1'b1;
                        hold.url_offset    = st.line_start + 16'd5;
                        hold.url_length    = cr_pos - st.line_start - 16'd5;
                    end
                    else if (is_get)
                    begin
                        hold.request_found = 1'b1;
                        hold.method_post   = 1'b0;
                        hold.url_offset    = st.line_start + 16'd4;
                        hold.url_length    = cr_pos - st.line_start - 16'd4;
                    end
                    else if (is_host)
                    begin
                        hold.host_found  = 1'b1;
                        hold.host_offset = st.line_start + 16'd6;
                        hold.host_length = ({1'b0, cr_pos} >= host_end)
                                           ? (cr_pos - st.line_start - 16'd6) : 16'd0;
                    end
                    st.line_start = st.pos + 16'd1;
                    st.prefix     = '0;
                    st.pcnt       = '0;
                    st.jel        = JEL_LF;
                    st.prev_cr    = 1'b0;
                end
            end
            else
            begin
                st.jel     = (b == CH_CR && st.jel == JEL_LF) ? JEL_LF_CR : JEL_NONE;
                st.prev_cr = (b == CH_CR);
                if (st.pcnt < 3'd5)
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        if (st.pcnt == 3'(k))
                        begin
                            st.prefix[8*k +: 8] = b;
                        end
                    end
                    st.pcnt = st.pcnt + 3'd1;
                end
            end
        end
        if (st.pos != 16'hffff)
        begin
            st.pos = st.pos + 16'd1;
        end
        result_item = hold;
        state_next  = st;
        hold_next   = hold;
        if (item.last_byte)
        begin
            state_next = '0;
            hold_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            hold_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

/* rtl/hrs_out_reg.sv */
// ----------------------------------------------------------------------------
// hrs_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hrs_out_reg
    import hrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      result_valid,
    input  out_item_t result_item,
    output logic      result_free,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign result_free = !valid_reg || !out_stall;
    assign out_valid   = valid_reg;
    assign out_item    = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (result_valid)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            item_reg <= result_item;
        end
    end

endmodule

/* rtl/http_request_header_scanner.sv */
// out_valid rises in the cycle after the last byte of a packet is taken.
// Throughput: one payload byte per cycle; the per-byte line scan is combinational.
// A result stalled downstream holds back the next last byte, but not other bytes.
// Reset (rst_n low, asynchronous): items and results dropped, parse state cleared,
// http_port back to 80, min_payload_length back to 16.
// ----------------------------------------------------------------------------
// http_request_header_scanner
// Scans a TCP payload for the request line, the Host header and the body start.
// ----------------------------------------------------------------------------
module http_request_header_scanner
    import hrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    hrs_cfg_t  cfg;
    logic      item_valid;
    in_item_t  item;
    logic      advance;
    logic      result_free;
    logic      result_valid;
    out_item_t result_item;

    hrs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hrs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    hrs_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item         (item),
        .result_free  (result_free),
        .advance      (advance),
        .result_valid (result_valid),
        .result_item  (result_item)
    );

    hrs_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (result_valid),
        .result_item  (result_item),
        .result_free  (result_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

endmodule

/* rtl/hrs_checker.sv */
// ----------------------------------------------------------------------------
// hrs_checker
// Port-level checks for the HTTP request header scanner, bound to the top.
// ----------------------------------------------------------------------------
`include "http_request_header_scanner_macros.svh"

module hrs_checker
    import hrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item
);

    `HRS_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
    `HRS_ASSERT_NOW(a_request_clean, clk, rst_n, out_valid && !out_item.request_found, !out_item.method_post && out_item.url_offset == 16'd0 && out_item.url_length == 16'd0, "request fields set without a request line")
    `HRS_ASSERT_NOW(a_host_clean, clk, rst_n, out_valid && !out_item.host_found, out_item.host_offset == 16'd0 && out_item.host_length == 16'd0, "host fields set without a Host line")
    `HRS_ASSERT_NOW(a_body_clean, clk, rst_n, out_valid && !out_item.body_found, out_item.body_offset == 16'd0 && out_item.body_length == 16'd0, "body fields set without a blank line")

endmodule

bind http_request_header_scanner hrs_checker u_hrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
